>>> rtl/core/tsjc_pkg.sv
package tsjc_pkg;

  localparam int MAX_SAMPLES = 256;
  localparam int CHANNELS    = 3;
  localparam int VEL_W       = 16;
  localparam int LIM_W       = 16;
  localparam int COST_W      = 32;
  localparam int SUM_W       = 48;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  // channel sum of three quotients below 2^48
  localparam int TOT_W       = SUM_W + 2;
  localparam int DVS_W       = (CNT_W + 2 > LIM_W) ? CNT_W + 2 : LIM_W;
  localparam int BIT_W       = $clog2(TOT_W + 1);
  localparam int D1_W        = VEL_W + 1;
  localparam int D2_W        = VEL_W + 2;
  localparam int SQ1_W       = 2 * VEL_W;
  localparam int SQ2_W       = 2 * VEL_W + 3;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ACC_X     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_Y     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_OMEGA = 2'd2;

  localparam logic [LIM_W-1:0] LIM_RESET = 16'd256;

  typedef logic [SUM_W-1:0] sum_t;

  typedef logic [CHANNELS-1:0][LIM_W-1:0] lims_t;

  typedef struct packed {
    sum_t [CHANNELS-1:0] sum_d;
    sum_t [CHANNELS-1:0] sum_j;
    logic [CNT_W-1:0]    cnt;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

>>> rtl/core/trajectory_smoothness_jerk_cost.sv
// Throughput: one sample per cycle until a finished trajectory finds the job queue full;
//   the shared bit-serial divider works through each trajectory's sums, skipping channels
//   whose limit is zero, and a two-entry job queue lets the sampler run ahead.
// Reset (rst_n low at a clock edge): limits return to 1.0, sums, history,
//   queue and output valid clear.
module trajectory_smoothness_jerk_cost (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [tsjc_pkg::VEL_W-1:0]    in_vel_x,
  input  logic signed [tsjc_pkg::VEL_W-1:0]    in_vel_y,
  input  logic signed [tsjc_pkg::VEL_W-1:0]    in_ang_vel,
  input  logic                                 in_last_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [tsjc_pkg::COST_W-1:0]          out_smooth_cost,
  output logic [tsjc_pkg::COST_W-1:0]          out_jerk_cost_out,
  output logic                                 out_saturated,
  input  logic                                 cfg_we,
  input  logic [tsjc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tsjc_pkg::LIM_W-1:0]           cfg_wdata
);

  tsjc_pkg::lims_t  lims_r;
  tsjc_pkg::job_t   job_in, head;
  tsjc_pkg::qstat_t qstat;
  logic             push, pop;
  logic [tsjc_pkg::CHANNELS-1:0][tsjc_pkg::VEL_W-1:0] vel;

  assign vel[0] = in_vel_x;
  assign vel[1] = in_vel_y;
  assign vel[2] = in_ang_vel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lims_r <= {tsjc_pkg::CHANNELS{tsjc_pkg::LIM_RESET}};
    end else if (cfg_we) begin
      case (cfg_index)
        tsjc_pkg::REG_ACC_X:     lims_r[0] <= cfg_wdata;
        tsjc_pkg::REG_ACC_Y:     lims_r[1] <= cfg_wdata;
        tsjc_pkg::REG_ACC_OMEGA: lims_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tsjc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .vel      (vel),
    .last     (in_last_sample),
    .qstat    (qstat),
    .push     (push),
    .job      (job_in)
  );

  tsjc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .job_in (job_in),
    .pop    (pop),
    .head   (head),
    .qstat  (qstat)
  );

  tsjc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .lims        (lims_r),
    .head        (head),
    .qstat       (qstat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .smooth_cost (out_smooth_cost),
    .jerk_val    (out_jerk_cost_out),
    .saturated   (out_saturated)
  );

endmodule

>>> rtl/core/tsjc_front.sv
module tsjc_front (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               in_valid,
  output logic                                               in_ready,
  input  logic [tsjc_pkg::CHANNELS-1:0][tsjc_pkg::VEL_W-1:0] vel,
  input  logic                                               last,
  input  tsjc_pkg::qstat_t                                   qstat,
  output logic                                               push,
  output tsjc_pkg::job_t                                     job
);

  localparam int CH = tsjc_pkg::CHANNELS;

  logic signed [tsjc_pkg::VEL_W-1:0] prev_r  [CH];
  logic signed [tsjc_pkg::VEL_W-1:0] prev2_r [CH];
  logic [tsjc_pkg::CNT_W-1:0]        cnt_r;
  logic [tsjc_pkg::CNT_W-1:0]        cnt_inc;

  logic                              s1_valid_r, s2_valid_r;
  logic signed [tsjc_pkg::D1_W-1:0]  s1_d1_r [CH];
  logic signed [tsjc_pkg::D2_W-1:0]  s1_d2_r [CH];
  logic                              s1_en1_r, s1_en2_r, s1_last_r;
  logic [tsjc_pkg::CNT_W-1:0]        s1_cnt_r;

  logic [tsjc_pkg::SQ1_W-1:0]        s2_sq1_r [CH];
  logic [tsjc_pkg::SQ2_W-1:0]        s2_sq2_r [CH];
  logic                              s2_last_r;
  logic [tsjc_pkg::CNT_W-1:0]        s2_cnt_r;

  tsjc_pkg::sum_t                    acc_d_r [CH];
  tsjc_pkg::sum_t                    acc_j_r [CH];
  tsjc_pkg::sum_t                    sum_d_nxt [CH];
  tsjc_pkg::sum_t                    sum_j_nxt [CH];

  logic signed [tsjc_pkg::D1_W-1:0]  d1 [CH];
  logic signed [tsjc_pkg::D2_W-1:0]  d2 [CH];
  logic signed [2*tsjc_pkg::D1_W-1:0] p1 [CH];
  logic signed [2*tsjc_pkg::D2_W-1:0] p2 [CH];

  logic advance, accept, live;

  // whole pipe stalls only while a finished trajectory waits for queue space
  assign advance  = !(s2_valid_r && s2_last_r && qstat.full);
  assign in_ready = advance;
  assign accept   = in_valid && advance;
  assign live     = cnt_r < tsjc_pkg::CNT_W'(tsjc_pkg::MAX_SAMPLES);
  assign cnt_inc  = cnt_r + 1'b1;

  always_comb begin
    for (int c = 0; c < CH; c++) begin
      d1[c] = tsjc_pkg::D1_W'($signed(vel[c])) - tsjc_pkg::D1_W'(prev_r[c]);
      d2[c] = tsjc_pkg::D2_W'($signed(vel[c])) - (tsjc_pkg::D2_W'(prev_r[c]) <<< 1)
              + tsjc_pkg::D2_W'(prev2_r[c]);
      p1[c] = s1_d1_r[c] * s1_d1_r[c];
      p2[c] = s1_d2_r[c] * s1_d2_r[c];
      sum_d_nxt[c] = acc_d_r[c] + tsjc_pkg::SUM_W'(s2_sq1_r[c]);
      sum_j_nxt[c] = acc_j_r[c] + tsjc_pkg::SUM_W'(s2_sq2_r[c]);
      job.sum_d[c] = sum_d_nxt[c];
      job.sum_j[c] = sum_j_nxt[c];
    end
    job.cnt = s2_cnt_r;
  end

  assign push = s2_valid_r && s2_last_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      for (int c = 0; c < CH; c++) begin
        prev_r[c]  <= '0;
        prev2_r[c] <= '0;
        acc_d_r[c] <= '0;
        acc_j_r[c] <= '0;
      end
    end else begin
      if (accept) begin
        if (last) begin
          cnt_r <= '0;
          for (int c = 0; c < CH; c++) begin
            prev_r[c]  <= '0;
            prev2_r[c] <= '0;
          end
        end else if (live) begin
          cnt_r <= cnt_inc;
          for (int c = 0; c < CH; c++) begin
            prev2_r[c] <= prev_r[c];
            prev_r[c]  <= $signed(vel[c]);
          end
        end
      end
      if (advance) begin
        s1_valid_r <= in_valid;
        s2_valid_r <= s1_valid_r;
      end
      if (advance && s2_valid_r) begin
        for (int c = 0; c < CH; c++) begin
          acc_d_r[c] <= s2_last_r ? '0 : sum_d_nxt[c];
          acc_j_r[c] <= s2_last_r ? '0 : sum_j_nxt[c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_en1_r  <= live && (cnt_r >= tsjc_pkg::CNT_W'(1));
      s1_en2_r  <= live && (cnt_r >= tsjc_pkg::CNT_W'(2));
      s1_last_r <= last;
      s1_cnt_r  <= live ? cnt_inc : cnt_r;
      s2_last_r <= s1_last_r;
      s2_cnt_r  <= s1_cnt_r;
      for (int c = 0; c < CH; c++) begin
        s1_d1_r[c]  <= d1[c];
        s1_d2_r[c]  <= d2[c];
        s2_sq1_r[c] <= s1_en1_r ? p1[c][tsjc_pkg::SQ1_W-1:0] : '0;
        s2_sq2_r[c] <= s1_en2_r ? p2[c][tsjc_pkg::SQ2_W-1:0] : '0;
      end
    end
  end

  a_last_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last |=> cnt_r == '0)
    else $error("sample count not cleared after last sample");

  a_last_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> job.cnt != '0)
    else $error("finished trajectory with zero samples");

endmodule

>>> rtl/core/tsjc_queue.sv
module tsjc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tsjc_pkg::job_t   job_in,
  input  logic             pop,
  output tsjc_pkg::job_t   head,
  output tsjc_pkg::qstat_t qstat
);

  localparam int QD = tsjc_pkg::QDEPTH;
  localparam int PW = tsjc_pkg::QPTR_W;

  tsjc_pkg::job_t mem_r [QD];
  logic [PW-1:0]  wp_r, rp_r;
  logic [PW:0]    n_r;

  assign qstat.full  = n_r == (PW+1)'(QD);
  assign qstat.empty = n_r == '0;
  assign head        = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      n_r  <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(QD - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(QD - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        n_r <= n_r + 1'b1;
      end else if (pop && !push) begin
        n_r <= n_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= job_in;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && qstat.full) && !(pop && qstat.empty))
    else $error("queue overrun or underrun");

endmodule

>>> rtl/core/tsjc_back.sv
module tsjc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tsjc_pkg::lims_t               lims,
  input  tsjc_pkg::job_t                head,
  input  tsjc_pkg::qstat_t              qstat,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tsjc_pkg::COST_W-1:0]   smooth_cost,
  output logic [tsjc_pkg::COST_W-1:0]   jerk_val,
  output logic                          saturated
);

  localparam int TW = tsjc_pkg::TOT_W;
  localparam int DW = tsjc_pkg::DVS_W;
  localparam int CW = tsjc_pkg::COST_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  // steps 0..2 smooth channels, 3 smooth cost, 4..6 jerk channels, 7 jerk cost
  localparam logic [2:0] STEP_COST_S = 3'd3;
  localparam logic [2:0] STEP_COST_J = 3'd7;

  logic [1:0]               state_r;
  logic [2:0]               step_r;
  tsjc_pkg::job_t           job_r;
  logic [TW-1:0]            tot_r, quo_r, quo_nxt;
  logic [DW-1:0]            rem_r, rem_nxt, dvs_r, div3;
  logic [tsjc_pkg::BIT_W-1:0] bits_r;
  logic [CW-1:0]            sc_r, jc_r, cost_val;
  logic                     sat_r, out_valid_r;
  logic [CW-1:0]            out_sc_r, out_jc_r;
  logic                     out_sat_r;

  logic [DW:0]              trial;
  logic                     ge, last_bit, is_cost, skip, out_free, hi_nz;
  logic [tsjc_pkg::LIM_W-1:0] lim_sel;
  tsjc_pkg::sum_t           sum_sel;

  always_comb begin
    case (step_r[1:0])
      2'd0:    lim_sel = lims[0];
      2'd1:    lim_sel = lims[1];
      2'd2:    lim_sel = lims[2];
      default: lim_sel = '0;
    endcase
    case (step_r[1:0])
      2'd0:    sum_sel = step_r[2] ? job_r.sum_j[0] : job_r.sum_d[0];
      2'd1:    sum_sel = step_r[2] ? job_r.sum_j[1] : job_r.sum_d[1];
      2'd2:    sum_sel = step_r[2] ? job_r.sum_j[2] : job_r.sum_d[2];
      default: sum_sel = '0;
    endcase
  end

  assign is_cost  = (step_r == STEP_COST_S) || (step_r == STEP_COST_J);
  assign skip     = !is_cost && (lim_sel == '0);
  assign div3     = DW'(job_r.cnt) + (DW'(job_r.cnt) << 1);

  // restoring divider, one quotient bit per cycle
  assign trial    = {rem_r, quo_r[TW-1]};
  assign ge       = trial >= {1'b0, dvs_r};
  assign rem_nxt  = ge ? DW'(trial - {1'b0, dvs_r}) : trial[DW-1:0];
  assign quo_nxt  = {quo_r[TW-2:0], ge};
  assign last_bit = bits_r == tsjc_pkg::BIT_W'(1);
  assign hi_nz    = |quo_nxt[TW-1:CW];
  assign cost_val = hi_nz ? '1 : quo_nxt[CW-1:0];

  assign out_free = !out_valid_r || out_ready;
  assign pop      = (state_r == S_IDLE) && !qstat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (!qstat.empty) begin
            state_r <= S_LOAD;
            step_r  <= '0;
          end
        end
        S_LOAD: begin
          if (skip) begin
            step_r <= step_r + 1'b1;
          end else begin
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (last_bit) begin
            if (step_r == STEP_COST_J) begin
              state_r <= S_FIN;
            end else begin
              step_r  <= step_r + 1'b1;
              state_r <= S_LOAD;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (!qstat.empty) begin
          job_r <= head;
          tot_r <= '0;
          sat_r <= 1'b0;
        end
      end
      S_LOAD: begin
        if (!skip) begin
          quo_r  <= is_cost ? tot_r : TW'(sum_sel);
          dvs_r  <= is_cost ? div3 : DW'(lim_sel);
          rem_r  <= '0;
          bits_r <= tsjc_pkg::BIT_W'(TW);
        end
      end
      S_RUN: begin
        quo_r  <= quo_nxt;
        rem_r  <= rem_nxt;
        bits_r <= bits_r - 1'b1;
        if (last_bit) begin
          if (is_cost) begin
            tot_r <= '0;
            sat_r <= sat_r | hi_nz;
            if (step_r == STEP_COST_S) begin
              sc_r <= cost_val;
            end else begin
              jc_r <= cost_val;
            end
          end else begin
            tot_r <= tot_r + quo_nxt;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_sc_r  <= sc_r;
          out_jc_r  <= jc_r;
          out_sat_r <= sat_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid   = out_valid_r;
  assign smooth_cost = out_sc_r;
  assign jerk_val    = out_jc_r;
  assign saturated   = out_sat_r;

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |-> dvs_r != '0)
    else $error("divider running with zero divisor");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result raised outside finish state");

endmodule
